// ===== design/tli_pkg.sv =====
// Shared types and constants of the table linear interpolator.
package tli_pkg;

  localparam int ENTRY_W = 6;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 7;
  localparam int INDEX_W = 7;
  localparam int WIDTH_W = 33;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [INDEX_W-1:0] MISS_INDEX = 7'h7F;

  // The divider retires one quotient bit per cycle over a 64-bit dividend.
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic               start_query;
    logic               shift_prev;
    logic               capture;
    logic               mul;
    logic               div_start;
    logic               load_out;
    logic               miss;
    logic [INDEX_W-1:0] seg_index;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic dw_zero;
    logic div_done;
  } status_t;

  function automatic logic [VALUE_W-1:0] mag33(input logic signed [VALUE_W:0] v);
    logic [VALUE_W:0] n;
    n = -v;
    return v[VALUE_W] ? n[VALUE_W-1:0] : v[VALUE_W-1:0];
  endfunction

endpackage

// ===== design/tli_in_if.sv =====
// Input channel interface carrying load and query words.
interface tli_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [tli_pkg::ENTRY_W-1:0]       entry_index;
  logic signed [tli_pkg::VALUE_W-1:0] x_value;
  logic signed [tli_pkg::VALUE_W-1:0] y_value;

  modport source (output valid, output opcode, output entry_index, output x_value,
                  output y_value, input ready);
  modport sink   (input valid, input opcode, input entry_index, input x_value,
                  input y_value, output ready);
endinterface

// ===== design/tli_out_if.sv =====
// Output channel interface carrying interpolation result words.
interface tli_out_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [tli_pkg::INDEX_W-1:0] start_index;
  logic signed [tli_pkg::WIDTH_W-1:0] step_width;
  logic signed [tli_pkg::VALUE_W-1:0] y_result;

  modport source (output valid, output found, output start_index, output step_width,
                  output y_result, input ready);
  modport sink   (input valid, input found, input start_index, input step_width,
                  input y_result, output ready);
endinterface

// ===== design/tli_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module tli_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  localparam int CNT_W = $clog2(tli_pkg::DIV_STEPS);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q;
  logic [63:0]      quo_q;
  logic [31:0]      dvs_q;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic        last;

  assign shifted = {rem_q, quo_q[63]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign last    = (cnt_q == CNT_W'(tli_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && !start_i && last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/tli_datapath.sv =====
// Datapath: breakpoint memory, segment arithmetic, divider and result registers.
module tli_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tli_pkg::cmd_t                      cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr_i,
  output tli_pkg::status_t                   status_o,
  input  logic [tli_pkg::ENTRY_W-1:0]        entry_index_i,
  input  logic signed [tli_pkg::VALUE_W-1:0] x_value_i,
  input  logic signed [tli_pkg::VALUE_W-1:0] y_value_i,
  output logic                               found_o,
  output logic signed [tli_pkg::INDEX_W-1:0] start_index_o,
  output logic signed [tli_pkg::WIDTH_W-1:0] step_width_o,
  output logic signed [tli_pkg::VALUE_W-1:0] y_result_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic signed [34:0] R_MAX = 35'sd2147483647;
  localparam logic signed [34:0] R_MIN = -35'sd2147483648;
  localparam logic [63:0] Q_LIMIT = 64'h0000_0002_0000_0000;

  logic [63:0] tbl_q [TABLE_DEPTH];
  logic [63:0] rdata_q;
  logic [63:0] prev_q;
  logic [31:0] xq_q;

  logic signed [32:0] dw_q, dy_q, dq_q;
  logic signed [31:0] y0_q;
  logic [63:0]        prod_q;
  logic               neg_q;

  logic               found_q;
  logic [6:0]         start_q;
  logic signed [32:0] width_q;
  logic signed [31:0] y_q;

  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic signed [32:0] x0e, x1e, y0e33, y1e, xqe;
  logic [63:0]        prod_d;
  logic               div_done;
  logic [63:0]        quo;
  logic               neg_eff;
  logic signed [34:0] y0e, qe, r;
  logic signed [31:0] y_fin;

  assign wr_ok   = cmd_i.wr_en && (int'(entry_index_i) < TABLE_DEPTH);
  assign wr_addr = AW'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      tbl_q[wr_addr] <= {x_value_i, y_value_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= tbl_q[rd_addr_i];
    end
  end

  assign x1e   = {rdata_q[63], rdata_q[63:32]};
  assign y1e   = {rdata_q[31], rdata_q[31:0]};
  assign x0e   = {prev_q[63], prev_q[63:32]};
  assign y0e33 = {prev_q[31], prev_q[31:0]};
  assign xqe   = {xq_q[31], xq_q};

  assign prod_d = 64'(tli_pkg::mag33(dy_q)) * 64'(tli_pkg::mag33(dq_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      xq_q <= x_value_i;
    end
    if (cmd_i.shift_prev) begin
      prev_q <= rdata_q;
    end
    if (cmd_i.capture) begin
      dw_q <= x1e - x0e;
      dy_q <= y1e - y0e33;
      dq_q <= xqe - x0e;
      y0_q <= prev_q[31:0];
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
      neg_q  <= dy_q[32] ^ dq_q[32] ^ dw_q[32];
    end
  end

  tli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (tli_pkg::mag33(dw_q)),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Apply the sign to the quotient, add to the start y and saturate; a zero-width segment gives the start y.
  assign neg_eff = neg_q && (quo != 64'd0);
  assign y0e     = {{3{y0_q[31]}}, y0_q};
  assign qe      = {1'b0, quo[33:0]};
  assign r       = neg_eff ? (y0e - qe) : (y0e + qe);

  always_comb begin
    if (dw_q == 33'sd0) begin
      y_fin = y0_q;
    end else if (quo > Q_LIMIT) begin
      y_fin = neg_eff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (r > R_MAX) begin
      y_fin = 32'sh7FFF_FFFF;
    end else if (r < R_MIN) begin
      y_fin = 32'sh8000_0000;
    end else begin
      y_fin = r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.miss) begin
        found_q <= 1'b0;
        start_q <= tli_pkg::MISS_INDEX;
        width_q <= '0;
        y_q     <= '0;
      end else begin
        found_q <= 1'b1;
        start_q <= cmd_i.seg_index;
        width_q <= dw_q;
        y_q     <= y_fin;
      end
    end
  end

  assign status_o.hit      = $signed(xq_q) < $signed(rdata_q[63:32]);
  assign status_o.dw_zero  = (dw_q == 33'sd0);
  assign status_o.div_done = div_done;

  assign found_o       = found_q;
  assign start_index_o = start_q;
  assign step_width_o  = width_q;
  assign y_result_o    = y_q;

endmodule

// ===== design/tli_ctrl.sv =====
// Controller: configuration register, scan sequencer and output valid.
module tli_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tli_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_opcode_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tli_pkg::cmd_t                  cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_o,
  input  tli_pkg::status_t               status_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = ($clog2(TABLE_DEPTH + 1) > 7) ? $clog2(TABLE_DEPTH + 1) : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic                      miss_q, miss_d;
  logic                      out_valid_q, out_valid_d;
  logic [tli_pkg::CFG_W-1:0] cfg_q;
  logic [CW-1:0]             count;
  logic [CW-1:0]             idx_nxt;
  logic                      in_acc;
  tli_pkg::cmd_t             cmd;

  assign count   = (int'(cfg_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cfg_q);
  assign idx_nxt = idx_q + CW'(1);
  assign in_acc  = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd       = '0;
    rd_addr_o = '0;
    state_d   = state_q;
    idx_d     = idx_q;
    miss_d    = miss_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode_i == tli_pkg::OP_LOAD) begin
            cmd.wr_en = 1'b1;
          end else if (count < CW'(2)) begin
            miss_d  = 1'b1;
            state_d = S_RES;
          end else begin
            cmd.rd_en       = 1'b1;
            cmd.start_query = 1'b1;
            idx_d           = '0;
            state_d         = S_PRIME;
          end
        end
      end
      S_PRIME: begin
        cmd.shift_prev = 1'b1;
        cmd.rd_en      = 1'b1;
        rd_addr_o      = AW'(idx_nxt);
        idx_d          = idx_nxt;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.hit) begin
          cmd.capture = 1'b1;
          miss_d      = 1'b0;
          state_d     = S_MUL;
        end else if (idx_nxt >= count) begin
          miss_d  = 1'b1;
          state_d = S_RES;
        end else begin
          cmd.shift_prev = 1'b1;
          cmd.rd_en      = 1'b1;
          rd_addr_o      = AW'(idx_nxt);
          idx_d          = idx_nxt;
        end
      end
      S_MUL: begin
        if (status_i.dw_zero) begin
          state_d = S_RES;
        end else begin
          cmd.mul = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_d       = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd.miss      = miss_q;
    cmd.seg_index = 7'(idx_q - CW'(1));
  end

  assign out_valid_d = cmd.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      miss_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= tli_pkg::CFG_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      miss_q      <= miss_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unaccepted word");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q < count))
    else $error("scan index beyond table entries in use");

  a_no_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status_i.dw_zero)
    else $error("divider started with zero width");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_opcode_i == tli_pkg::OP_QUERY)) |=> !in_ready_o)
    else $error("input still ready after a query was taken");

endmodule

// ===== design/table_linear_interpolator_unit.sv =====
// Top level of the piecewise linear table interpolator.
// A load word writes one breakpoint as it is taken; a new word can follow at once.
// A query hitting segment j makes one memory read per scanned breakpoint, then one
// multiply and a run of the bit-serial divider; a miss or a zero-width segment
// skips the multiply and the divider.
// Reset clears the sequencer and output valid and sets table_entries to 64; breakpoint
// memory is not cleared and holds undefined data until written.
module table_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tli_pkg::CFG_W-1:0] cfg_wdata_i,
  tli_in_if.sink                    item_i,
  tli_out_if.source                 result_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // Command and status between the sequencer and the datapath.
  tli_pkg::cmd_t    cmd;
  tli_pkg::status_t status;
  logic [AW-1:0]    rd_addr;

  // The controller owns the table_entries register, the scan index and the
  // output valid flag. Input is ready only while no query is in flight, but a
  // finished result word may still sit in the output register meanwhile.
  tli_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (item_i.valid),
    .in_opcode_i (item_i.opcode),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .status_i    (status)
  );

  // The datapath keeps x and y of each breakpoint in one memory word, so a
  // single read port walks the table while the previous entry is held aside
  // as the segment start.
  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .status_o      (status),
    .entry_index_i (item_i.entry_index),
    .x_value_i     (item_i.x_value),
    .y_value_i     (item_i.y_value),
    .found_o       (result_o.found),
    .start_index_o (result_o.start_index),
    .step_width_o  (result_o.step_width),
    .y_result_o    (result_o.y_result)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the piecewise linear table interpolator.
module tb_top;

  localparam int TBL_DEPTH = 64;

  // The stimulus stops adding words once this many have been queued.
  localparam int WORD_BUDGET = 1350;

  // Longest correct stretch without any handshake is the receiver hold-off plus one slow
  // query; the watchdog allows several times that.
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 12000;

  // Loads are written as they are taken, so a short pause covers them.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 200;

  localparam logic signed [tli_pkg::VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [tli_pkg::VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

  // One load or query word as the sender offers it.
  typedef struct packed {
    logic                               opcode;
    logic [tli_pkg::ENTRY_W-1:0]        slot;
    logic signed [tli_pkg::VALUE_W-1:0] x;
    logic signed [tli_pkg::VALUE_W-1:0] y;
  } table_word_t;

  // The fields of one result word.
  typedef struct packed {
    logic                               found;
    logic signed [tli_pkg::INDEX_W-1:0] start_index;
    logic signed [tli_pkg::WIDTH_W-1:0] step_width;
    logic signed [tli_pkg::VALUE_W-1:0] y_result;
  } segment_hit_t;

  // An expected result together with the cycle its query was taken in. A result seen in
  // that same cycle cannot belong to it, which keeps the check independent of the order
  // in which the driver and the monitor run within a time step.
  typedef struct {
    segment_hit_t hit;
    longint       stamp;
  } due_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY,
    RX_BURSTY
  } rx_mode_e;

  logic clk;
  logic rst_n;
  logic                      cfg_we    = 1'b0;
  logic [tli_pkg::CFG_W-1:0] cfg_wdata = '0;

  tli_in_if  item_ch ();
  tli_out_if result_ch ();

  table_linear_interpolator_unit #(
    .TABLE_DEPTH (TBL_DEPTH)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  // Words waiting to be offered, and results waiting to be seen.
  table_word_t word_queue [$];
  due_t        interp_due [$];

  // Predicted copy of the breakpoint table and of the entry count register.
  logic signed [tli_pkg::VALUE_W-1:0] pred_x [TBL_DEPTH];
  logic signed [tli_pkg::VALUE_W-1:0] pred_y [TBL_DEPTH];
  int unsigned                        pred_count = 32'(tli_pkg::CFG_RESET);

  // The stimulus side's own view of the table, used only to aim queries.
  logic signed [tli_pkg::VALUE_W-1:0] gen_x [TBL_DEPTH];
  logic signed [tli_pkg::VALUE_W-1:0] gen_y [TBL_DEPTH];

  int     items_made    = 0;
  int     fail_count    = 0;
  longint cyc           = 0;
  int     quiet         = 0;
  int     hold_asks     = 0;
  int     holds_granted = 0;
  int     hold_left     = 0;

  // Sender burst state.
  int          burst_left = 0;
  int          gap_left   = 0;
  table_word_t next_word;

  // Receiver stall state.
  rx_mode_e rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       rx_tick    = 0;
  int       stall_left = 0;
  logic     take;
  due_t     head;
  due_t     due_entry;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sign-extends a Q16.16 value to the 33-bit difference width.
  function automatic logic signed [tli_pkg::WIDTH_W-1:0] widen(
      input logic signed [tli_pkg::VALUE_W-1:0] v);
    return {v[tli_pkg::VALUE_W-1], v};
  endfunction

  function automatic logic signed [tli_pkg::VALUE_W-1:0] clamp32(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[tli_pkg::VALUE_W-1:0];
  endfunction

  // Scans the predicted table for the first breakpoint above the query and interpolates
  // across the segment that ends there. The product of the y and x differences is exact
  // and is divided once; the quotient is truncated toward zero before saturation.
  function automatic segment_hit_t interpolate_query(
      input logic signed [tli_pkg::VALUE_W-1:0] xq);
    segment_hit_t r;
    int unsigned  n;
    int unsigned  i;
    logic signed [tli_pkg::WIDTH_W-1:0] dw;
    logic signed [tli_pkg::WIDTH_W-1:0] dy;
    logic signed [tli_pkg::WIDTH_W-1:0] dq;
    logic [tli_pkg::WIDTH_W-1:0] mw;
    logic [tli_pkg::WIDTH_W-1:0] my;
    logic [tli_pkg::WIDTH_W-1:0] mq;
    logic [63:0] quo;
    logic        neg;
    longint      acc;
    r.found       = 1'b0;
    r.start_index = tli_pkg::MISS_INDEX;
    r.step_width  = '0;
    r.y_result    = '0;
    // Counts above the table depth behave as the full table.
    n = (pred_count > TBL_DEPTH) ? TBL_DEPTH : pred_count;
    for (i = 1; i < n; i++) begin
      if (xq < pred_x[i]) begin
        dw = widen(pred_x[i]) - widen(pred_x[i-1]);
        dy = widen(pred_y[i]) - widen(pred_y[i-1]);
        dq = widen(xq) - widen(pred_x[i-1]);
        r.found       = 1'b1;
        r.start_index = tli_pkg::INDEX_W'(i - 1);
        r.step_width  = dw;
        if (dw == 0) begin
          // A segment of zero width gives its start y.
          r.y_result = pred_y[i-1];
        end else begin
          mw  = dw[tli_pkg::WIDTH_W-1] ? -dw : dw;
          my  = dy[tli_pkg::WIDTH_W-1] ? -dy : dy;
          mq  = dq[tli_pkg::WIDTH_W-1] ? -dq : dq;
          quo = ({31'b0, my} * {31'b0, mq}) / {31'b0, mw};
          neg = dy[tli_pkg::WIDTH_W-1] ^ dq[tli_pkg::WIDTH_W-1] ^ dw[tli_pkg::WIDTH_W-1];
          if (quo == 0) neg = 1'b0;
          if (quo > 64'h2_0000_0000) begin
            r.y_result = neg ? Q_MIN : Q_MAX;
          end else begin
            acc = longint'(pred_y[i-1]);
            acc = neg ? acc - longint'(quo) : acc + longint'(quo);
            r.y_result = clamp32(acc);
          end
        end
        return r;
      end
    end
    return r;
  endfunction

  // One line per failure, and every failure is counted.
  task automatic flag_error(input string what);
    fail_count++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic queue_load(input logic [tli_pkg::ENTRY_W-1:0] slot,
                            input logic signed [tli_pkg::VALUE_W-1:0] x,
                            input logic signed [tli_pkg::VALUE_W-1:0] y);
    table_word_t w;
    w.opcode = tli_pkg::OP_LOAD;
    w.slot   = slot;
    w.x      = x;
    w.y      = y;
    word_queue.push_back(w);
    gen_x[slot] = x;
    gen_y[slot] = y;
    items_made++;
  endtask

  // Queries carry random slot and y bits, which the block must ignore.
  task automatic queue_query(input logic signed [tli_pkg::VALUE_W-1:0] x);
    table_word_t w;
    w.opcode = tli_pkg::OP_QUERY;
    w.slot   = tli_pkg::ENTRY_W'($urandom);
    w.x      = x;
    w.y      = $urandom;
    word_queue.push_back(w);
    items_made++;
  endtask

  // Waits on the falling edge, where everything driven at the rising edge has settled,
  // until every word has been taken and every result has come back.
  task automatic wait_drained();
    while (word_queue.size() != 0 || item_ch.valid || interp_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The count register is only written with the block idle.
  task automatic set_table_entries(input logic [tli_pkg::CFG_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    pred_count  = 32'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: predicts each word on the edge that takes it, then offers the next word
  // from the queue in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.opcode == tli_pkg::OP_QUERY) begin
          due_entry.hit   = interpolate_query(item_ch.x_value);
          due_entry.stamp = cyc;
          interp_due.push_back(due_entry);
        end else begin
          pred_x[item_ch.entry_index] = item_ch.x_value;
          pred_y[item_ch.entry_index] = item_ch.y_value;
        end
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            // A long stretch with no idling at all.
            burst_left = 200;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        if (burst_left > 0 && word_queue.size() > 0) begin
          next_word = word_queue.pop_front();
          item_ch.opcode      <= next_word.opcode;
          item_ch.entry_index <= next_word.slot;
          item_ch.x_value     <= next_word.x;
          item_ch.y_value     <= next_word.y;
          item_ch.valid       <= 1'b1;
          burst_left--;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest expectation, then picks the next
  // value of ready from a stall pattern that is itself redrawn at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (interp_due.size() == 0 || interp_due[0].stamp == cyc) begin
          flag_error($sformatf("result word with no query waiting (found=%0b y=%0d)",
                               result_ch.found, result_ch.y_result));
        end else begin
          head = interp_due.pop_front();
          if (result_ch.found !== head.hit.found)
            flag_error($sformatf("found got %0b want %0b", result_ch.found, head.hit.found));
          if (result_ch.start_index !== head.hit.start_index)
            flag_error($sformatf("start_index got %0d want %0d",
                                 result_ch.start_index, head.hit.start_index));
          if (result_ch.step_width !== head.hit.step_width)
            flag_error($sformatf("step_width got %0d want %0d",
                                 result_ch.step_width, head.hit.step_width));
          if (result_ch.y_result !== head.hit.y_result)
            flag_error($sformatf("y_result got %0d want %0d",
                                 result_ch.y_result, head.hit.y_result));
        end
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(40, 400);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   take = 1'b1;
        RX_COIN:   take = 1'($urandom_range(0, 1));
        RX_EVERY4: take = (rx_tick % 4 == 0);
        RX_MOSTLY: take = ($urandom_range(0, 7) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            take = 1'b0;
          end else begin
            take = 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 30);
          end
        end
      endcase
      // A long hold-off overrides the pattern so the block backs up into its input.
      if (hold_left > 0) take = 1'b0;
      result_ch.ready <= take;
    end
  end

  // Counts out a receiver hold-off each time the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_asks != holds_granted) begin
      holds_granted <= hold_asks;
      hold_left     <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Cycle counter and watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("table_linear_interpolator_unit verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned cnt;
    int unsigned used;
    int unsigned pick;
    int unsigned shape;
    int unsigned scale;
    int unsigned nq;
    int unsigned sel;
    int unsigned j;
    int          k;
    int          q;
    int          phase_no;
    bit          pressure;
    longint      px;
    longint      diff;
    longint      offs;
    logic signed [tli_pkg::VALUE_W-1:0] xv;
    logic signed [tli_pkg::VALUE_W-1:0] yv;
    logic signed [tli_pkg::VALUE_W-1:0] qx;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Full-range table: segment 0 spans the most negative x up to zero with y falling
    // from the top of the range to the bottom, and the last breakpoint is the largest x.
    set_table_entries(7'd4);
    queue_load(6'd0, Q_MIN, Q_MAX);
    queue_load(6'd1, 32'sh0000_0000, Q_MIN);
    queue_load(6'd2, 32'sh0001_0000, 32'sh0003_0000);
    queue_load(6'd3, Q_MAX, 32'shFFFF_0000);
    queue_query(Q_MIN);
    queue_query(-32'sd1);
    queue_query(32'sh0000_0000);
    queue_query(32'sh0000_8000);
    queue_query(32'sh7FFF_FFFE);
    // Not below any breakpoint, so a miss.
    queue_query(Q_MAX);
    // The highest slot is written once here.
    queue_load(6'd63, Q_MAX, Q_MIN);

    // Zero or one entries in use always miss.
    set_table_entries(7'd0);
    queue_query(32'sh0001_0000);
    set_table_entries(7'd1);
    queue_query(Q_MIN);

    // A steep first segment: queries below its start extrapolate, far enough to saturate.
    set_table_entries(7'd3);
    queue_load(6'd0, 32'sh0000_0000, 32'sh7000_0000);
    queue_load(6'd1, 32'sh0000_0001, Q_MAX);
    queue_load(6'd2, 32'sh0010_0000, 32'sh0000_0000);
    queue_query(Q_MIN);
    queue_query(-32'sd16);
    queue_query(32'sh0008_0000);

    // Two breakpoints at the same x: a query below them hits a segment of zero width.
    set_table_entries(7'd2);
    queue_load(6'd0, 32'sh0000_0100, 32'sh1234_5678);
    queue_load(6'd1, 32'sh0000_0100, 32'sh0000_0000);
    queue_query(32'sh0000_0000);
    queue_query(32'sh0000_0100);

    // Random phases. Each sets a new entry count, reloads the table in use, mostly
    // sorted, then queries around the breakpoints with a few stray loads mixed in.
    phase_no = 0;
    while (items_made < WORD_BUDGET) begin
      phase_no++;
      pressure = (phase_no == 3 || phase_no == 30);
      pick     = $urandom_range(0, 19);
      if (pick == 0) cnt = 0;
      else if (pick == 1) cnt = 1;
      else if (pick == 2) cnt = 64;
      else if (pick == 3) cnt = (($urandom_range(0, 1) == 0) ? 127 : $urandom_range(65, 126));
      else if (pick <= 5) cnt = $urandom_range(9, 63);
      else cnt = $urandom_range(2, 8);
      if (pressure) cnt = 8;
      set_table_entries(tli_pkg::CFG_W'(cnt));
      used = (cnt > TBL_DEPTH) ? TBL_DEPTH : cnt;

      // Shapes 0..6 rise at every step until they clamp at the top, 7..8 rise with repeats, 9 is unsorted.
      shape = $urandom_range(0, 9);
      scale = $urandom_range(0, 26);
      px    = ($urandom_range(0, 7) == 0) ? longint'(Q_MIN)
                                          : longint'($signed($urandom) >>> $urandom_range(0, 8));
      for (k = 0; k < used; k++) begin
        if (shape == 9) begin
          xv = $urandom;
        end else begin
          if (k > 0) begin
            if (shape >= 7 && $urandom_range(0, 2) == 0) px = px;
            else px = px + longint'($urandom_range(1, 1 << scale));
          end
          xv = clamp32(px);
        end
        yv = ($urandom_range(0, 1) == 0) ? $signed($urandom) : ($signed($urandom) >>> 12);
        queue_load(tli_pkg::ENTRY_W'(k), xv, yv);
      end

      if (pressure) hold_asks++;
      nq = pressure ? 40 : ((used < 2) ? 3 : $urandom_range(6, 24));
      for (q = 0; q < nq; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray load anywhere in the table, which may also break its order.
          queue_load(tli_pkg::ENTRY_W'($urandom), $urandom, $urandom);
        end else if (used < 2) begin
          qx = ($urandom_range(0, 1) == 0) ? $urandom
                                           : (($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX);
          queue_query(qx);
        end else begin
          j   = $urandom_range(0, used - 1);
          sel = $urandom_range(0, 9);
          if (sel <= 2) begin
            qx = gen_x[j];
          end else if (sel == 3) begin
            qx = clamp32(longint'(gen_x[j]) + (($urandom_range(0, 1) == 0) ? -1 : 1));
          end else if (sel <= 6) begin
            diff = (j + 1 < used) ? longint'(gen_x[j+1]) - longint'(gen_x[j]) : 0;
            if (diff > 1) begin
              offs = {32'b0, $urandom};
              qx   = clamp32(longint'(gen_x[j]) + offs % diff);
            end else begin
              qx = $urandom;
            end
          end else if (sel == 7) begin
            qx = $urandom;
          end else if (sel == 8) begin
            qx = ($urandom_range(0, 1) == 0) ? Q_MIN : Q_MAX;
          end else begin
            // Below the first breakpoint, to extrapolate from segment 0.
            offs = {32'b0, $urandom} >> $urandom_range(0, 31);
            qx   = clamp32(longint'(gen_x[0]) - offs - 1);
          end
          queue_query(qx);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("table_linear_interpolator_unit verification clean");
    end else begin
      $display("table_linear_interpolator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tli_pkg.sv
design/tli_in_if.sv
design/tli_out_if.sv
design/tli_div.sv
design/tli_datapath.sv
design/tli_ctrl.sv
design/table_linear_interpolator_unit.sv
bench/tb_top.sv
